// ===== hdl/mre_pkg.sv =====
// Shared types, opcode constants and helpers for the mini RISC executor.
`default_nettype none

package mre_pkg;

    // Default sizes of the architectural state
    localparam int unsigned DATA_WIDTH_DEF = 16;
    localparam int unsigned DATA_DEPTH_DEF = 256;
    localparam int unsigned REG_COUNT_DEF  = 8;

    // Result queue depth, also the bound on items in flight
    localparam int unsigned OUTQ_DEPTH = 4;

    // Commands
    localparam logic CMD_EXEC    = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;

    // Opcodes, instruction bits 15:12
    localparam logic [3:0] OP_RTYPE = 4'b0000;
    localparam logic [3:0] OP_JUMP  = 4'b0010;
    localparam logic [3:0] OP_ADDI  = 4'b0100;
    localparam logic [3:0] OP_BEQ   = 4'b1000;
    localparam logic [3:0] OP_LW    = 4'b1011;
    localparam logic [3:0] OP_SW    = 4'b1111;

    // R-type function codes; anything else adds
    localparam logic [2:0] FN_SUB = 3'd2;
    localparam logic [2:0] FN_AND = 3'd4;
    localparam logic [2:0] FN_OR  = 3'd5;

    // Input item
    typedef struct packed {
        logic               command;
        logic [15:0]        instruction;
        logic [7:0]         preload_address;
        logic signed [15:0] preload_value;
    } t_item;

    // Result item
    typedef struct packed {
        logic [7:0]         next_pc;
        logic               illegal;
        logic               reg_written;
        logic [2:0]         reg_number;
        logic signed [15:0] reg_result;
        logic               mem_written;
        logic [7:0]         mem_address;
        logic signed [15:0] mem_result;
        logic               branch_taken;
    } t_result;

    // Byte address reduced modulo a depth of 16 to 256 words: the quotient
    // fits in four bits, so four conditional subtractions are enough.
    function automatic logic [7:0] wrap_addr(input logic [7:0] value,
                                             input int unsigned depth);
        logic [11:0] rem;
        rem = {4'd0, value};
        for (int k = 3; k >= 0; k--) begin
            if (rem >= 12'(depth << k)) begin
                rem = rem - 12'(depth << k);
            end
        end
        return rem[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mre_regfile.sv =====
// Register file: two registered read ports with write bypass, one write port.
`default_nettype none

module mre_regfile
    import mre_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned REG_COUNT  = REG_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [$clog2(REG_COUNT)-1:0]  i_rd_addr_a,
    input  wire logic [$clog2(REG_COUNT)-1:0]  i_rd_addr_b,
    output logic      [DATA_WIDTH-1:0]         o_rd_data_a,
    output logic      [DATA_WIDTH-1:0]         o_rd_data_b,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(REG_COUNT)-1:0]  i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0]         i_wr_data
);

    logic [DATA_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_written;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;
    logic [DATA_WIDTH-1:0] n_rd_a;
    logic [DATA_WIDTH-1:0] n_rd_b;

    // Read data: a write on the same edge wins, unwritten entries read zero
    always_comb begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            n_rd_a = i_wr_data;
        end else if (r_written[i_rd_addr_a]) begin
            n_rd_a = r_mem[i_rd_addr_a];
        end else begin
            n_rd_a = '0;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            n_rd_b = i_wr_data;
        end else if (r_written[i_rd_addr_b]) begin
            n_rd_b = r_mem[i_rd_addr_b];
        end else begin
            n_rd_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= n_rd_a;
        r_rd_b <= n_rd_b;
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Entry valid bits stand in for clearing the array at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// ===== hdl/mre_dmem.sv =====
// Data memory: one write port, one registered read port, per-word valid bits.
`default_nettype none

module mre_dmem
    import mre_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(DATA_DEPTH)-1:0]  i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0]          i_wr_data,
    input  wire logic [$clog2(DATA_DEPTH)-1:0]  i_rd_addr,
    output logic      [DATA_WIDTH-1:0]          o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] r_written;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_rd_valid;

    // Array write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Valid bits: a word never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_written[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/mre_outq.sv =====
// Result queue between the pipeline and the output channel.
`default_nettype none

module mre_outq
    import mre_pkg::*;
#(
    parameter int unsigned DEPTH = OUTQ_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire t_result                      i_data,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output t_result                           o_data,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result          r_buf [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             pop;

    assign pop = (r_count != '0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level; the producer never pushes into a full queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/mini_risc_instruction_executor.sv =====
// Top level: three-stage executor around the register file and data memory.
`default_nettype none

// Executes one 16-bit instruction, or one data memory preload, per input
// transfer and returns one result per transfer, in order. Sustained rate is
// one item per clock. The register file is read at the input transfer, the
// execute stage does the ALU, branch and address work and the data memory
// access, and the writeback stage returns load data and writes the register
// file; results pass from the writeback stage into a four-entry queue and
// wait there for the output. Results of earlier instructions are
// forwarded to later ones, so back-to-back dependent items never stall. Input
// ready drops only when four items are in flight or queued, i.e. when the
// output side holds off. The register file and data memory come out of
// reset cleared through per-entry valid bits; no clearing pass is needed.
module mini_risc_instruction_executor
    import mre_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int unsigned REG_COUNT  = REG_COUNT_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_item   i_item,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    localparam int unsigned RW    = $clog2(REG_COUNT);
    localparam int unsigned AW    = $clog2(DATA_DEPTH);
    localparam int unsigned CW    = $clog2(OUTQ_DEPTH + 1);
    localparam int unsigned EXT_W = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;

    typedef struct packed {
        t_result               res;
        logic                  is_load;
        logic                  reg_we;
        logic [2:0]            reg_num;
        logic [DATA_WIDTH-1:0] alu;
    } t_wb;

    // Pipeline registers
    logic                  r_ex_valid;
    t_item                 r_ex_item;
    logic                  r_wb_valid;
    t_wb                   r_wb;
    logic [7:0]            r_pc;

    logic                  accept;
    logic [CW-1:0]         q_count;
    logic [CW+1:0]         in_flight;

    logic [DATA_WIDTH-1:0] rf_a;
    logic [DATA_WIDTH-1:0] rf_b;
    logic [DATA_WIDTH-1:0] dm_rd_data;
    logic [DATA_WIDTH-1:0] wb_data;
    t_result               wb_res;

    // Execute stage signals
    logic [3:0]            op;
    logic [2:0]            rs;
    logic [2:0]            rt;
    logic [2:0]            rd;
    logic [2:0]            fn;
    logic [5:0]            imm6;
    logic [DATA_WIDTH-1:0] imm_w;
    logic [DATA_WIDTH-1:0] opnd_a;
    logic [DATA_WIDTH-1:0] opnd_b;
    logic [DATA_WIDTH-1:0] alu;
    logic [7:0]            pc_inc;
    logic [7:0]            ex_addr;
    logic [7:0]            pre_addr;
    logic [DATA_WIDTH-1:0] pre_word;
    logic                  dm_wr_en;
    logic [AW-1:0]         dm_wr_addr;
    logic [DATA_WIDTH-1:0] dm_wr_data;
    t_wb                   n_wb;

    // Input side: accept while fewer than a queue's worth of items are held
    assign in_flight = (CW+2)'(q_count) + (CW+2)'(r_ex_valid) + (CW+2)'(r_wb_valid);
    assign o_ready   = (in_flight < (CW+2)'(OUTQ_DEPTH));
    assign accept    = i_valid && o_ready;

    mre_regfile #(
        .DATA_WIDTH (DATA_WIDTH),
        .REG_COUNT  (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (RW'(i_item.instruction[11:9])),
        .i_rd_addr_b (RW'(i_item.instruction[8:6])),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b),
        .i_wr_en     (r_wb_valid && r_wb.reg_we),
        .i_wr_addr   (RW'(r_wb.reg_num)),
        .i_wr_data   (wb_data)
    );

    // Decode fields of the item in execute
    assign op   = r_ex_item.instruction[15:12];
    assign rs   = r_ex_item.instruction[11:9];
    assign rt   = r_ex_item.instruction[8:6];
    assign rd   = r_ex_item.instruction[5:3];
    assign fn   = r_ex_item.instruction[2:0];
    assign imm6 = r_ex_item.instruction[5:0];
    assign imm_w = {{(DATA_WIDTH-6){imm6[5]}}, imm6};

    // Forward the writeback value to the operands of the next instruction
    assign opnd_a = (r_wb_valid && r_wb.reg_we && (r_wb.reg_num == rs)) ? wb_data : rf_a;
    assign opnd_b = (r_wb_valid && r_wb.reg_we && (r_wb.reg_num == rt)) ? wb_data : rf_b;

    // ALU
    always_comb begin
        if (op == OP_ADDI) begin
            alu = opnd_a + imm_w;
        end else begin
            unique case (fn)
                FN_SUB:  alu = opnd_a - opnd_b;
                FN_AND:  alu = opnd_a & opnd_b;
                FN_OR:   alu = opnd_a | opnd_b;
                default: alu = opnd_a + opnd_b;
            endcase
        end
    end

    assign pc_inc   = r_pc + 8'd1;
    assign ex_addr  = wrap_addr(opnd_a[7:0] + {{2{imm6[5]}}, imm6}, DATA_DEPTH);
    assign pre_addr = wrap_addr(r_ex_item.preload_address, DATA_DEPTH);
    assign pre_word = DATA_WIDTH'(EXT_W'(r_ex_item.preload_value[15:0]));

    // Execute: next PC, memory access and the result fields known here
    always_comb begin
        n_wb         = '0;
        n_wb.alu     = alu;
        n_wb.res.next_pc = r_pc;
        dm_wr_en     = 1'b0;
        dm_wr_addr   = ex_addr[AW-1:0];
        dm_wr_data   = opnd_b;
        if (r_ex_item.command == CMD_PRELOAD) begin
            dm_wr_en   = r_ex_valid;
            dm_wr_addr = pre_addr[AW-1:0];
            dm_wr_data = pre_word;
            n_wb.res.mem_written = 1'b1;
            n_wb.res.mem_address = pre_addr;
            n_wb.res.mem_result  = EXT_W'(pre_word);
        end else begin
            n_wb.res.next_pc = pc_inc;
            unique case (op)
                OP_RTYPE: begin
                    n_wb.reg_we  = 1'b1;
                    n_wb.reg_num = rd;
                end
                OP_JUMP: begin
                    n_wb.res.next_pc      = {1'b0, r_ex_item.instruction[6:0]} + 8'd1;
                    n_wb.res.branch_taken = 1'b1;
                end
                OP_ADDI: begin
                    n_wb.reg_we  = 1'b1;
                    n_wb.reg_num = rt;
                end
                OP_BEQ: begin
                    if (opnd_a == opnd_b) begin
                        n_wb.res.next_pc      = pc_inc + {{2{imm6[5]}}, imm6};
                        n_wb.res.branch_taken = 1'b1;
                    end
                end
                OP_LW: begin
                    n_wb.is_load = 1'b1;
                    n_wb.reg_we  = 1'b1;
                    n_wb.reg_num = rt;
                    n_wb.res.mem_address = ex_addr;
                end
                OP_SW: begin
                    dm_wr_en = r_ex_valid;
                    n_wb.res.mem_written = 1'b1;
                    n_wb.res.mem_address = ex_addr;
                    n_wb.res.mem_result  = EXT_W'(opnd_b);
                end
                default: begin
                    n_wb.res.next_pc = r_pc;
                    n_wb.res.illegal = 1'b1;
                end
            endcase
        end
        n_wb.res.reg_written = n_wb.reg_we;
        n_wb.res.reg_number  = n_wb.reg_num;
    end

    mre_dmem #(
        .DATA_WIDTH (DATA_WIDTH),
        .DATA_DEPTH (DATA_DEPTH)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (dm_wr_en),
        .i_wr_addr (dm_wr_addr),
        .i_wr_data (dm_wr_data),
        .i_rd_addr (ex_addr[AW-1:0]),
        .o_rd_data (dm_rd_data)
    );

    // Writeback: load data arrives from the memory, register value chosen
    assign wb_data = r_wb.is_load ? dm_rd_data : r_wb.alu;

    always_comb begin
        wb_res = r_wb.res;
        if (r_wb.reg_we) begin
            wb_res.reg_result = EXT_W'(wb_data);
        end
        if (r_wb.is_load) begin
            wb_res.mem_result = EXT_W'(dm_rd_data);
        end
    end

    // Stage registers and program counter
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex_item <= i_item;
        end
        r_wb <= n_wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_wb_valid <= 1'b0;
            r_pc       <= '0;
        end else begin
            r_ex_valid <= accept;
            r_wb_valid <= r_ex_valid;
            if (r_ex_valid) begin
                r_pc <= n_wb.res.next_pc;
            end
        end
    end

    mre_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_wb_valid),
        .i_data  (wb_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_result),
        .o_count (q_count)
    );

endmodule

`default_nettype wire
